### rtl/rdc_pkg.sv
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_K1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_K2    = 3'd6;

  localparam int DIM_W   = 13;
  localparam int FOCAL_W = 20;
  localparam int COEF_W  = 20;

  localparam logic [DIM_W-1:0]   RST_SRC_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_SRC_HEIGHT = 13'd480;
  localparam logic [DIM_W-1:0]   RST_DST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_DST_HEIGHT = 13'd480;
  localparam logic [FOCAL_W-1:0] RST_FOCAL      = 20'd153600;

  // datapath widths
  localparam int OUT_W  = 24;
  localparam int R2_W   = 24;
  localparam int R4_W   = 32;
  localparam int F2_W   = 2 * FOCAL_W;
  localparam int QUOT_W = 41;
  localparam int DEN_W  = 54;
  localparam int DENU_W = DEN_W - 1;
  localparam int R2_SH  = 6;

  // sideband that rides along the quotient divider
  typedef struct packed {
    logic bad;
    logic den_bad;
    logic sign_u;
    logic ovf_u;
    logic sign_v;
    logic ovf_v;
  } qside_t;

endpackage

### rtl/rdc_pix_if.sv
`timescale 1ns / 1ps

interface rdc_pix_if #(
  parameter int COORD_BITS = rdc_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;

  modport source (output valid, output pix_x, output pix_y, input ready);
  modport sink   (input valid, input pix_x, input pix_y, output ready);
endinterface

### rtl/rdc_coord_if.sv
`timescale 1ns / 1ps

interface rdc_coord_if;
  logic                               valid;
  logic                               ready;
  logic signed [rdc_pkg::OUT_W-1:0]   src_u;
  logic signed [rdc_pkg::OUT_W-1:0]   src_v;
  logic                               invalid;

  modport source (output valid, output src_u, output src_v, output invalid, input ready);
  modport sink   (input valid, input src_u, input src_v, input invalid, output ready);
endinterface

### rtl/rdc_div.sv
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage, lanes share the divisor
module rdc_div #(
  parameter int DVW = rdc_pkg::F2_W,
  parameter int QW  = rdc_pkg::R2_W,
  parameter int NL  = 1,
  parameter int SBW = 1
)(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld_in,
  input  logic [NL-1:0][DVW-1:0]    rem_in,
  input  logic [NL-1:0][QW-1:0]     num_lo,
  input  logic [DVW-1:0]            dvsr,
  input  logic [SBW-1:0]            side_in,
  output logic                      vld_out,
  output logic [NL-1:0][QW-1:0]     quot,
  output logic [SBW-1:0]            side_out
);

  logic [QW-1:0]             vld_r;
  logic [DVW-1:0]            dv_r   [QW];
  logic [NL-1:0][DVW-1:0]    rem_r  [QW];
  logic [NL-1:0][QW-1:0]     num_r  [QW];
  logic [NL-1:0][QW-1:0]     q_r    [QW];
  logic [SBW-1:0]            side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic                   vld_c;
    logic [DVW-1:0]         dv_c;
    logic [NL-1:0][DVW-1:0] rem_c;
    logic [NL-1:0][QW-1:0]  num_c;
    logic [NL-1:0][QW-1:0]  q_c;
    logic [SBW-1:0]         side_c;
    logic [NL-1:0][DVW-1:0] rem_next;
    logic [NL-1:0][QW-1:0]  num_next;
    logic [NL-1:0][QW-1:0]  q_next;

    if (i == 0) begin : g_first
      assign vld_c  = vld_in;
      assign dv_c   = dvsr;
      assign rem_c  = rem_in;
      assign num_c  = num_lo;
      assign q_c    = '0;
      assign side_c = side_in;
    end else begin : g_next
      assign vld_c  = vld_r[i-1];
      assign dv_c   = dv_r[i-1];
      assign rem_c  = rem_r[i-1];
      assign num_c  = num_r[i-1];
      assign q_c    = q_r[i-1];
      assign side_c = side_r[i-1];
    end

    always_comb begin
      logic [DVW:0] t;
      logic         ge;
      for (int l = 0; l < NL; l++) begin
        t  = {rem_c[l], num_c[l][QW-1]};
        ge = t >= {1'b0, dv_c};
        rem_next[l] = ge ? DVW'(t - {1'b0, dv_c}) : t[DVW-1:0];
        num_next[l] = {num_c[l][QW-2:0], 1'b0};
        q_next[l]   = {q_c[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[i]   <= dv_c;
        rem_r[i]  <= rem_next;
        num_r[i]  <= num_next;
        q_r[i]    <= q_next;
        side_r[i] <= side_c;
      end
    end
  end

  assign vld_out  = vld_r[QW-1];
  assign quot     = q_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

### rtl/radial_distortion_coord_map.sv
`timescale 1ns / 1ps

// channel  | modport | payload                      | request moves
// ---------+---------+------------------------------+------------------------------
// pix      | sink    | pix_x, pix_y                 | destination pixel in
// coord    | source  | src_u, src_v, invalid        | source coordinate out
// cfg      | write   | cfg_we, cfg_index, cfg_data  | register write, no wait
//
// one request accepted per clock unless coord stalls; each request passes through
// 3 front stages, 24 stages of the radius divider, 5 polynomial and numerator
// stages, 41 stages of the shared u/v quotient divider, combine and output register
// rst is synchronous: pipeline valid bits clear, registers load their defaults
// a stall on coord freezes the whole pipe in place, pix.ready follows at once

module radial_distortion_coord_map #(
  parameter int COORD_BITS = rdc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rdc_pkg::FRAC_BITS_DEF
)(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rdc_pkg::CFG_DATA_W-1:0]   cfg_data,
  rdc_pix_if.sink                          pix,
  rdc_coord_if.source                      coord
);

  // offsets in half pixels: 2*pix - dst_size
  localparam int D2W  = (COORD_BITS + 2 > rdc_pkg::DIM_W + 1) ? COORD_BITS + 2
                                                              : rdc_pkg::DIM_W + 1;
  localparam int SW   = 2 * D2W;                 // sum of squares
  localparam int R0W  = SW + rdc_pkg::R2_SH;     // s * 2^30 / 2^24
  localparam int F2W  = rdc_pkg::F2_W;
  localparam int CW   = (R0W > F2W) ? R0W : F2W;
  localparam int QW2  = rdc_pkg::QUOT_W;
  localparam int DVW2 = rdc_pkg::DENU_W;
  localparam int SH   = FRAC_BITS + 31;          // FRAC_BITS - 1 + 32
  localparam int NW   = ((D2W + SH > DVW2) ? D2W + SH : DVW2) + 1;
  localparam int RHW  = NW - QW2;
  localparam int CW2  = (RHW > DVW2) ? RHW : DVW2;
  localparam int CUW  = rdc_pkg::DIM_W + FRAC_BITS;
  localparam int OW   = ((QW2 + 1 > CUW) ? QW2 + 1 : CUW) + 1;
  localparam int OUT_W = rdc_pkg::OUT_W;
  localparam int R2_W  = rdc_pkg::R2_W;
  localparam int R4_W  = rdc_pkg::R4_W;
  localparam int DEN_W = rdc_pkg::DEN_W;

  localparam logic [QW2-1:0]       QCAP   = QW2'(1) << (QW2 - 1);
  localparam logic signed [OW-1:0] SAT_HI = OW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);
  localparam logic signed [DEN_W-1:0] DEN_ONE = DEN_W'(1) << 32;

  // ---------------------------------------------------------------- registers
  logic [rdc_pkg::DIM_W-1:0]          src_width, src_height, dst_width, dst_height;
  logic [rdc_pkg::FOCAL_W-1:0]        focal_length;
  logic signed [rdc_pkg::COEF_W-1:0]  coef_k1, coef_k2;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= rdc_pkg::RST_SRC_WIDTH;
      src_height   <= rdc_pkg::RST_SRC_HEIGHT;
      dst_width    <= rdc_pkg::RST_DST_WIDTH;
      dst_height   <= rdc_pkg::RST_DST_HEIGHT;
      focal_length <= rdc_pkg::RST_FOCAL;
      coef_k1      <= '0;
      coef_k2      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rdc_pkg::CFG_SRC_WIDTH:  src_width    <= cfg_data[rdc_pkg::DIM_W-1:0];
        rdc_pkg::CFG_SRC_HEIGHT: src_height   <= cfg_data[rdc_pkg::DIM_W-1:0];
        rdc_pkg::CFG_DST_WIDTH:  dst_width    <= cfg_data[rdc_pkg::DIM_W-1:0];
        rdc_pkg::CFG_DST_HEIGHT: dst_height   <= cfg_data[rdc_pkg::DIM_W-1:0];
        rdc_pkg::CFG_FOCAL:      focal_length <= cfg_data[rdc_pkg::FOCAL_W-1:0];
        rdc_pkg::CFG_COEF_K1:    coef_k1      <= $signed(cfg_data[rdc_pkg::COEF_W-1:0]);
        rdc_pkg::CFG_COEF_K2:    coef_k2      <= $signed(cfg_data[rdc_pkg::COEF_W-1:0]);
        default: ;
      endcase
    end
  end

  // whole pipe moves together; it only holds when the output register is full and stalled
  logic en;
  logic vout;
  assign en        = !vout || coord.ready;
  assign pix.ready = en;

  // ---------------------------------------------------------------- stage 1
  // centred offsets and f^2 (zero focal length counts as one lsb)
  logic                    v1;
  logic signed [D2W-1:0]   dx1, dy1;
  logic [F2W-1:0]          f2_1;
  logic [rdc_pkg::FOCAL_W-1:0] fval;

  assign fval = (focal_length == '0) ? rdc_pkg::FOCAL_W'(1) : focal_length;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= pix.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= $signed({{(D2W-COORD_BITS-1){1'b0}}, pix.pix_x, 1'b0})
            - $signed({{(D2W-rdc_pkg::DIM_W){1'b0}}, dst_width});
      dy1  <= $signed({{(D2W-COORD_BITS-1){1'b0}}, pix.pix_y, 1'b0})
            - $signed({{(D2W-rdc_pkg::DIM_W){1'b0}}, dst_height});
      f2_1 <= F2W'(fval) * F2W'(fval);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // squares of the offsets
  logic                  v2;
  logic signed [D2W-1:0] dx2, dy2;
  logic [F2W-1:0]        f2_2;
  logic [SW-1:0]         sqx, sqy;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx2  <= dx1;
      dy2  <= dy1;
      f2_2 <= f2_1;
      sqx  <= SW'(dx1 * dx1);
      sqy  <= SW'(dy1 * dy1);
    end
  end

  // ---------------------------------------------------------------- stage 3
  // r2 overflow check: quotient reaches 2^24 when s*2^6 >= f^2
  logic                  v3, ovf3;
  logic signed [D2W-1:0] dx3, dy3;
  logic [F2W-1:0]        f2_3, rem3;
  logic [R0W-1:0]        rem0;

  assign rem0 = {sqx + sqy, {rdc_pkg::R2_SH{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx3  <= dx2;
      dy3  <= dy2;
      f2_3 <= f2_2;
      ovf3 <= CW'(rem0) >= CW'(f2_2);
      rem3 <= F2W'(CW'(rem0));
    end
  end

  // ---------------------------------------------------------------- radius divider
  // low numerator bits of s*2^30 are all zero, so nothing is shifted in
  logic                  v4, ovf4;
  logic signed [D2W-1:0] dx4, dy4;
  logic [0:0][R2_W-1:0]  q4;

  rdc_div #(
    .DVW (F2W),
    .QW  (R2_W),
    .NL  (1),
    .SBW (1 + 2 * D2W)
  ) u_r2_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (v3),
    .rem_in   (rem3),
    .num_lo   ('0),
    .dvsr     (f2_3),
    .side_in  ({ovf3, dx3, dy3}),
    .vld_out  (v4),
    .quot     (q4),
    .side_out ({ovf4, dx4, dy4})
  );

  // ---------------------------------------------------------------- stage 5
  // saturate r2, then r2^2 and k1*r2
  logic                         v5, bad5;
  logic signed [D2W-1:0]        dx5, dy5;
  logic [R2_W-1:0]              r2;
  logic [2*R2_W-1:0]            r2sq5;
  logic signed [rdc_pkg::COEF_W+R2_W:0] p1_5;

  assign r2 = ovf4 ? '1 : q4[0];

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad5  <= ovf4;
      dx5   <= dx4;
      dy5   <= dy4;
      r2sq5 <= (2*R2_W)'(r2) * (2*R2_W)'(r2);
      p1_5  <= coef_k1 * $signed({1'b0, r2});
    end
  end

  // ---------------------------------------------------------------- stage 6
  // k2*r4 with r4 = r2^2 / 2^16
  logic                         v6, bad6;
  logic signed [D2W-1:0]        dx6, dy6;
  logic signed [rdc_pkg::COEF_W+R2_W:0] p1_6;
  logic signed [rdc_pkg::COEF_W+R4_W:0] p2_6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad6 <= bad5;
      dx6  <= dx5;
      dy6  <= dy5;
      p1_6 <= p1_5;
      p2_6 <= coef_k2 * $signed({1'b0, r2sq5[2*R2_W-1:16]});
    end
  end

  // ---------------------------------------------------------------- stage 7
  // denominator 1 + k1*r2 + k2*r4 in q.32
  logic                    v7, bad7;
  logic signed [D2W-1:0]   dx7, dy7;
  logic signed [DEN_W-1:0] den7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad7 <= bad6;
      dx7  <= dx6;
      dy7  <= dy6;
      den7 <= DEN_ONE + DEN_W'(p1_6) + DEN_W'(p2_6);
    end
  end

  // ---------------------------------------------------------------- stage 8
  // rounded numerators |d| * 2^(frac+31) + den/2
  logic              v8, bad8, den_bad8, sgn_u8, sgn_v8;
  logic [DVW2-1:0]   den8;
  logic [NW-1:0]     nu8, nv8;
  logic [D2W-1:0]    mag_u, mag_v;

  assign mag_u = dx7[D2W-1] ? D2W'(-dx7) : D2W'(dx7);
  assign mag_v = dy7[D2W-1] ? D2W'(-dy7) : D2W'(dy7);

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad8     <= bad7;
      den_bad8 <= den7[DEN_W-1] || (den7 == '0);
      sgn_u8   <= dx7[D2W-1];
      sgn_v8   <= dy7[D2W-1];
      den8     <= den7[DVW2-1:0];
      nu8      <= (NW'(mag_u) << SH) + NW'(den7[DVW2-1:1]);
      nv8      <= (NW'(mag_v) << SH) + NW'(den7[DVW2-1:1]);
    end
  end

  // ---------------------------------------------------------------- stage 9
  // quotient overflow check: the top part of the numerator against den
  logic                     v9;
  rdc_pkg::qside_t          side9;
  logic [DVW2-1:0]          den9;
  logic [1:0][DVW2-1:0]     rem9;
  logic [1:0][QW2-1:0]      lo9;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side9.bad     <= bad8;
      side9.den_bad <= den_bad8;
      side9.sign_u  <= sgn_u8;
      side9.sign_v  <= sgn_v8;
      side9.ovf_u   <= CW2'(nu8[NW-1:QW2]) >= CW2'(den8);
      side9.ovf_v   <= CW2'(nv8[NW-1:QW2]) >= CW2'(den8);
      den9          <= den8;
      rem9[0]       <= DVW2'(CW2'(nu8[NW-1:QW2]));
      rem9[1]       <= DVW2'(CW2'(nv8[NW-1:QW2]));
      lo9[0]        <= nu8[QW2-1:0];
      lo9[1]        <= nv8[QW2-1:0];
    end
  end

  // ---------------------------------------------------------------- quotient divider
  logic                 v10;
  rdc_pkg::qside_t      side10;
  logic [1:0][QW2-1:0]  q10;

  rdc_div #(
    .DVW (DVW2),
    .QW  (QW2),
    .NL  (2),
    .SBW ($bits(rdc_pkg::qside_t))
  ) u_uv_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (v9),
    .rem_in   (rem9),
    .num_lo   (lo9),
    .dvsr     (den9),
    .side_in  (side9),
    .vld_out  (v10),
    .quot     (q10),
    .side_out (side10)
  );

  // ---------------------------------------------------------------- stage 11
  // cap the quotient, apply sign, add the source centre
  logic                 v11, bad11, den_bad11;
  logic signed [OW-1:0] sum_u, sum_v;
  logic [QW2-1:0]       qc_u, qc_v;
  logic signed [OW-1:0] cu, cv;

  assign qc_u = (side10.ovf_u || q10[0] > QCAP) ? QCAP : q10[0];
  assign qc_v = (side10.ovf_v || q10[1] > QCAP) ? QCAP : q10[1];
  assign cu   = $signed(OW'(src_width)  << (FRAC_BITS - 1));
  assign cv   = $signed(OW'(src_height) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad11     <= side10.bad;
      den_bad11 <= side10.den_bad;
      sum_u     <= side10.sign_u ? cu - $signed(OW'(qc_u)) : cu + $signed(OW'(qc_u));
      sum_v     <= side10.sign_v ? cv - $signed(OW'(qc_v)) : cv + $signed(OW'(qc_v));
    end
  end

  // ---------------------------------------------------------------- output register
  // saturate to 24 bits; a non-positive denominator forces zero and the flag
  logic sat_u_hi, sat_u_lo, sat_v_hi, sat_v_lo;

  assign sat_u_hi = sum_u > SAT_HI;
  assign sat_u_lo = sum_u < SAT_LO;
  assign sat_v_hi = sum_v > SAT_HI;
  assign sat_v_lo = sum_v < SAT_LO;

  always_ff @(posedge clk) begin
    if (rst) vout <= 1'b0;
    else if (en) vout <= v11;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (den_bad11) begin
        coord.src_u   <= '0;
        coord.src_v   <= '0;
        coord.invalid <= 1'b1;
      end else begin
        coord.src_u   <= sat_u_hi ? OUT_W'(SAT_HI) : sat_u_lo ? OUT_W'(SAT_LO) : OUT_W'(sum_u);
        coord.src_v   <= sat_v_hi ? OUT_W'(SAT_HI) : sat_v_lo ? OUT_W'(SAT_LO) : OUT_W'(sum_v);
        coord.invalid <= bad11 || sat_u_hi || sat_u_lo || sat_v_hi || sat_v_lo;
      end
    end
  end

  assign coord.valid = vout;

endmodule

### rtl/rdc_checker.sv
`timescale 1ns / 1ps

module rdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rdc_pkg::OUT_W-1:0]     src_u,
  input logic [rdc_pkg::OUT_W-1:0]     src_v,
  input logic                          invalid
);

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // input side only holds back while a result waits on a stalled output
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // a stalled result is still shown, unchanged, in the next cycle
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(src_u) && $stable(src_v)
                                  && $stable(invalid))
    else $error("stalled result changed");

  // a stall blocks input acceptance
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(in_valid && in_ready))
    else $error("request taken during output stall");

endmodule

bind radial_distortion_coord_map rdc_checker u_rdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix.valid),
  .in_ready  (pix.ready),
  .out_valid (coord.valid),
  .out_ready (coord.ready),
  .src_u     (coord.src_u),
  .src_v     (coord.src_v),
  .invalid   (coord.invalid)
);

### test/radial_distortion_coord_map_tb.sv
`timescale 1ns / 1ps

module radial_distortion_coord_map_tb;

  // one expected source coordinate
  typedef struct {
    logic signed [rdc_pkg::OUT_W-1:0] u;
    logic signed [rdc_pkg::OUT_W-1:0] v;
    logic                             inv;
  } coord_t;

  // expected-coordinate store with its own copy of the registers
  class coord_scoreboard;
    longint unsigned src_w = 640, src_h = 480, dst_w = 640, dst_h = 480;
    longint unsigned focal = 153600;
    longint          k1 = 0, k2 = 0;
    coord_t          expected_q[$];
    int              mismatches = 0;

    function void set_reg(logic [rdc_pkg::CFG_IDX_W-1:0] idx,
                          logic [rdc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rdc_pkg::CFG_SRC_WIDTH:  src_w = data[rdc_pkg::DIM_W-1:0];
        rdc_pkg::CFG_SRC_HEIGHT: src_h = data[rdc_pkg::DIM_W-1:0];
        rdc_pkg::CFG_DST_WIDTH:  dst_w = data[rdc_pkg::DIM_W-1:0];
        rdc_pkg::CFG_DST_HEIGHT: dst_h = data[rdc_pkg::DIM_W-1:0];
        rdc_pkg::CFG_FOCAL:      focal = data;
        rdc_pkg::CFG_COEF_K1:    k1 = longint'(signed'(data));
        rdc_pkg::CFG_COEF_K2:    k2 = longint'(signed'(data));
        default: ;
      endcase
    endfunction

    // offset / denominator, rounded half away from zero, magnitude capped
    function longint scaled_offset(longint off2, longint den);
      longint unsigned mag, q;
      mag = off2 < 0 ? -off2 : off2;
      q = ((mag << 39) + longint'(den) / 2) / longint'(den);
      if (q > 64'd1099511627776) q = 64'd1099511627776;
      return off2 < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint clamp_out(longint val, ref logic bad);
      if (val > 8388607) begin
        bad = 1;
        return 8388607;
      end
      if (val < -8388608) begin
        bad = 1;
        return -8388608;
      end
      return val;
    endfunction

    function void note_request(logic [11:0] x, logic [11:0] y);
      longint          dx2, dy2, den, uu, vv;
      longint unsigned s, f, r2, r4;
      logic            bad;
      coord_t          c;
      dx2 = 2 * longint'(x) - longint'(dst_w);
      dy2 = 2 * longint'(y) - longint'(dst_h);
      s = dx2 * dx2 + dy2 * dy2;
      f = focal == 0 ? 1 : focal;
      r2 = (s << 30) / (f * f);
      bad = 0;
      if (r2 > 64'd16777215) begin
        r2 = 64'd16777215;
        bad = 1;
      end
      r4 = (r2 * r2) >> 16;
      den = (longint'(1) << 32) + k1 * longint'(r2) + k2 * longint'(r4);
      if (den <= 0) begin
        uu = 0;
        vv = 0;
        bad = 1;
      end else begin
        uu = clamp_out(longint'(src_w << 7) + scaled_offset(dx2, den), bad);
        vv = clamp_out(longint'(src_h << 7) + scaled_offset(dy2, den), bad);
      end
      c.u = uu[rdc_pkg::OUT_W-1:0];
      c.v = vv[rdc_pkg::OUT_W-1:0];
      c.inv = bad;
      expected_q.push_back(c);
    endfunction

    function void check_result(logic signed [rdc_pkg::OUT_W-1:0] u,
                               logic signed [rdc_pkg::OUT_W-1:0] v,
                               logic inv);
      coord_t c;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected coordinate u=%0d v=%0d inv=%0b", u, v, inv);
        return;
      end
      c = expected_q.pop_front();
      if (u !== c.u || v !== c.v || inv !== c.inv) begin
        mismatches++;
        if (mismatches <= 10)
          $display("coordinate mismatch: expected u=%0d v=%0d inv=%0b, got u=%0d v=%0d inv=%0b",
                   c.u, c.v, c.inv, u, v, inv);
      end
    endfunction
  endclass

  logic clk, rst;
  logic                           cfg_we;
  logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rdc_pkg::CFG_DATA_W-1:0] cfg_data;

  rdc_pix_if   pix_ch ();
  rdc_coord_if coord_ch ();

  radial_distortion_coord_map i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix       (pix_ch),
    .coord     (coord_ch)
  );

  coord_scoreboard sb = new();
  bit calm;        // no idling on either side while set
  int quiet_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, changed on the falling edge
  always @(negedge clk) begin
    coord_ch.ready <= calm || ($urandom_range(99) >= 17);
  end

  // every accepted coordinate is compared against the oldest expectation
  always @(posedge clk) begin
    if (!rst && coord_ch.valid && coord_ch.ready)
      sb.check_result(coord_ch.src_u, coord_ch.src_v, coord_ch.invalid);
  end

  // watchdog: counts cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((pix_ch.valid && pix_ch.ready) || (coord_ch.valid && coord_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("** radial_distortion_coord_map: FAILED **");
      $finish;
    end
  end

  // register write, pipe must be empty
  task automatic write_reg(logic [rdc_pkg::CFG_IDX_W-1:0] idx,
                           logic [rdc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic write_all(int sw, int sh, int dw, int dh, int f, int c1, int c2);
    write_reg(rdc_pkg::CFG_SRC_WIDTH,  rdc_pkg::CFG_DATA_W'(sw));
    write_reg(rdc_pkg::CFG_SRC_HEIGHT, rdc_pkg::CFG_DATA_W'(sh));
    write_reg(rdc_pkg::CFG_DST_WIDTH,  rdc_pkg::CFG_DATA_W'(dw));
    write_reg(rdc_pkg::CFG_DST_HEIGHT, rdc_pkg::CFG_DATA_W'(dh));
    write_reg(rdc_pkg::CFG_FOCAL,      rdc_pkg::CFG_DATA_W'(f));
    write_reg(rdc_pkg::CFG_COEF_K1,    rdc_pkg::CFG_DATA_W'(c1));
    write_reg(rdc_pkg::CFG_COEF_K2,    rdc_pkg::CFG_DATA_W'(c2));
  endtask

  // one pixel request, with an occasional idle cycle beforehand
  task automatic send_pixel(logic [11:0] x, logic [11:0] y);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 17) begin
      pix_ch.valid <= 0;
      @(negedge clk);
    end
    pix_ch.valid <= 1;
    pix_ch.pix_x <= x;
    pix_ch.pix_y <= y;
    do @(posedge clk); while (!pix_ch.ready);
    sb.note_request(x, y);
  endtask

  // stop sending until every coordinate is back, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    pix_ch.valid <= 0;
    wait (sb.expected_q.size() == 0);
    repeat (90) @(posedge clk);
  endtask

  // random pixels: mostly inside the destination frame, some anywhere
  task automatic random_pixels(int n);
    int dw, dh;
    dw = sb.dst_w > 4096 ? 4096 : (sb.dst_w == 0 ? 1 : sb.dst_w);
    dh = sb.dst_h > 4096 ? 4096 : (sb.dst_h == 0 ? 1 : sb.dst_h);
    repeat (n) begin
      if ($urandom_range(9) < 7)
        send_pixel(12'($urandom_range(dw - 1)), 12'($urandom_range(dh - 1)));
      else
        send_pixel(12'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = rdc_pkg::CFG_SRC_WIDTH;
    cfg_data = 0;
    pix_ch.valid = 0;
    pix_ch.pix_x = 0;
    pix_ch.pix_y = 0;
    coord_ch.ready = 0;
    calm = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // defaults after reset: corners, centre and field extremes
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(320, 240);
    send_pixel(0, 12'hFFF);
    send_pixel(12'hFFF, 0);
    send_pixel(639, 479);
    send_pixel(12'hAAA, 12'h555);
    drain();

    // barrel distortion with negative k1 strong enough to make the denominator non-positive
    write_reg(rdc_pkg::CFG_COEF_K1, -20'sd524288);
    send_pixel(0, 0);
    send_pixel(320, 240);
    send_pixel(100, 100);
    send_pixel(639, 0);
    drain();

    // zero focal length: radius saturates
    write_all(8191, 8191, 8191, 8191, 0, 524287, 524287);
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 0);
    drain();

    // widest focal length, most negative coefficients, zero-sized frames
    write_all(0, 0, 0, 0, 1048575, -524288, -524288);
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(2048, 1024);
    send_pixel(1, 1);
    drain();

    // small frame, tiny focal length: the radius saturates
    write_all(1, 1, 1, 1, 1, 0, 0);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();

    // random phases; one long stretch without idling on either side
    for (int ph = 0; ph < 8; ph++) begin
      int dw, dh;
      dw = $urandom_range(1, 4096);
      dh = $urandom_range(1, 4096);
      write_all($urandom_range(1, 4096), $urandom_range(1, 4096), dw, dh,
                ph == 0 ? 1048575 : $urandom_range(256, (dw > dh ? dw : dh) * 256 + 256),
                ph == 1 ? 0 : $signed($urandom_range(0, 20'hFFFFF) << 12) >>> 12,
                ph == 2 ? 0 : $signed($urandom_range(0, 20'hFFFFF) << 12) >>> 12);
      calm = (ph == 3);
      random_pixels(150);
      calm = 0;
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("** radial_distortion_coord_map: PASSED **");
    else
      $display("** radial_distortion_coord_map: FAILED **");
    $finish;
  end

endmodule
